// ----- hdl/ssc_pkg.sv -----
// ----------------------------------------------------------------------------
// ssc_pkg: shared types and constants for the scan set change counter
// Sizes of the identifier sets, field widths, register indexes, the
// controller state type and the control bundle that drives the cell row.
// ----------------------------------------------------------------------------
package ssc_pkg;

  // Set sizing
  localparam int SET_CAPACITY = 32;
  localparam int CNT_W        = $clog2(SET_CAPACITY + 1);
  localparam int STEP_W       = $clog2(SET_CAPACITY);

  // Field widths
  localparam int ID_W        = 48;
  localparam int TOTAL_W     = 31;
  localparam int OUT_CNT_W   = 6;
  localparam int MINC_W      = 7;
  localparam int CMP_W       = 8;
  localparam int OUT_DATA_W  = 48;
  localparam int OUT_USED_W  = TOTAL_W + 2 + 2 * OUT_CNT_W;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Divide by three as multiply by 43 and shift by 7 (exact below 128)
  localparam int DIV3_MUL   = 43;
  localparam int DIV3_SHIFT = 7;

  // Configuration register indexes
  localparam int REG_ADDR_W = 1;
  localparam logic [REG_ADDR_W-1:0] REG_ENABLED    = 1'd0;
  localparam logic [REG_ADDR_W-1:0] REG_MIN_CHANGE = 1'd1;

  localparam logic [MINC_W-1:0] MIN_CHANGE_RST = 7'd3;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_LOAD,
    ST_COUNT,
    ST_FINISH
  } state_t;

  // Commands broadcast to every cell
  typedef struct packed {
    logic append;    // shift a new identifier in at cell 0
    logic start;     // clear match marks for a new comparison
    logic rotate;    // compare, then rotate the current set one cell
    logic load;      // capture miss flags
    logic shift;     // move miss flags one cell toward the tail
    logic transfer;  // current set becomes the previous set
  } cell_ctl_t;

endpackage

// ----- hdl/ssc_cell.sv -----
// ----------------------------------------------------------------------------
// ssc_cell: one cell of the identifier row
// Holds one previous-scan entry and one current-scan entry. The current
// entry travels along the ring during comparison, carrying its found mark.
// ----------------------------------------------------------------------------
module ssc_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  ssc_pkg::cell_ctl_t      ctl,
  input  logic [ssc_pkg::ID_W-1:0] id_in,
  input  logic                    valid_in,
  input  logic                    found_in,
  input  logic                    gone_in,
  input  logic                    fresh_in,
  output logic [ssc_pkg::ID_W-1:0] id_out,
  output logic                    valid_out,
  output logic                    found_out,
  output logic                    gone_out,
  output logic                    fresh_out
);

  logic [ssc_pkg::ID_W-1:0] prev_id;
  logic                     prev_v;
  logic                     matched;
  logic [ssc_pkg::ID_W-1:0] cur_id;
  logic                     cur_v;
  logic                     found;
  logic                     gone_flag;
  logic                     fresh_flag;
  logic                     hit;

  // Compare the resident previous entry with the passing current entry
  assign hit = prev_v && cur_v && (prev_id == cur_id);

  assign id_out    = cur_id;
  assign valid_out = cur_v;
  assign found_out = found || hit;
  assign gone_out  = gone_flag;
  assign fresh_out = fresh_flag;

  // Validity of both entries
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_v <= 1'b0;
      cur_v  <= 1'b0;
    end else if (ctl.transfer) begin
      prev_v <= cur_v;
      cur_v  <= 1'b0;
    end else if (ctl.append || ctl.rotate) begin
      cur_v <= valid_in;
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    if (ctl.transfer) begin
      prev_id <= cur_id;
    end
    if (ctl.append || ctl.rotate) begin
      cur_id <= id_in;
    end
  end

  // Match marks
  always_ff @(posedge clk) begin
    if (rst) begin
      matched <= 1'b0;
      found   <= 1'b0;
    end else begin
      if (ctl.start) begin
        matched <= 1'b0;
      end else if (ctl.rotate) begin
        matched <= matched || hit;
      end
      if (ctl.append || ctl.start) begin
        found <= 1'b0;
      end else if (ctl.rotate) begin
        found <= found_in;
      end
    end
  end

  // Miss flags, drained toward the tail for counting
  always_ff @(posedge clk) begin
    if (rst) begin
      gone_flag  <= 1'b0;
      fresh_flag <= 1'b0;
    end else if (ctl.load) begin
      gone_flag  <= prev_v && !matched;
      fresh_flag <= cur_v && !found;
    end else if (ctl.shift) begin
      gone_flag  <= gone_in;
      fresh_flag <= fresh_in;
    end
  end

endmodule

// ----- hdl/ssc_ctrl.sv -----
// ----------------------------------------------------------------------------
// ssc_ctrl: sequencer, counters and result register
// Takes input beats and configuration writes, steps the cell row through
// rotation and miss counting, applies the threshold and holds the result.
// ----------------------------------------------------------------------------
module ssc_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ssc_pkg::REG_ADDR_W-1:0]      cfg_addr,
  input  logic [ssc_pkg::MINC_W-1:0]          cfg_wdata,
  input  logic                                s_tvalid,
  input  logic                                s_tlast,
  input  logic                                s_tuser,
  output logic                                s_tready,
  input  logic                                m_tready,
  output logic                                m_tvalid,
  output logic [ssc_pkg::OUT_DATA_W-1:0]      m_tdata,
  input  logic                                tail_gone,
  input  logic                                tail_fresh,
  output ssc_pkg::cell_ctl_t                  ctl
);

  ssc_pkg::state_t                   state;
  ssc_pkg::state_t                   state_next;
  logic                              enabled;
  logic [ssc_pkg::MINC_W-1:0]        min_change;
  logic [ssc_pkg::CNT_W-1:0]         cur_count;
  logic [ssc_pkg::CNT_W-1:0]         prev_count;
  logic [ssc_pkg::CNT_W-1:0]         cur_count_next;
  logic [ssc_pkg::CNT_W-1:0]         gone;
  logic [ssc_pkg::CNT_W-1:0]         fresh;
  logic [ssc_pkg::STEP_W-1:0]        step;
  logic                              compared;
  logic [ssc_pkg::TOTAL_W-1:0]       change_total;
  logic                              accept;
  logic                              append;
  logic                              terminal;
  logic                              step_end;
  logic                              fire;
  logic                              slot_free;
  logic [ssc_pkg::CNT_W-1:0]         larger;
  logic [ssc_pkg::CNT_W+5:0]         prod;
  logic [ssc_pkg::MINC_W-1:0]        third;
  logic [ssc_pkg::MINC_W-1:0]        thresh;
  logic [ssc_pkg::CNT_W:0]           sum;
  logic                              changed;
  logic [ssc_pkg::TOTAL_W-1:0]       total_next;

  // Input beat decode
  assign accept   = s_tvalid && s_tready;
  assign append   = accept && enabled && !s_tuser &&
                    (cur_count < ssc_pkg::CNT_W'(ssc_pkg::SET_CAPACITY));
  assign terminal = accept && enabled && (s_tlast || s_tuser);
  assign cur_count_next = cur_count + ssc_pkg::CNT_W'(append);
  assign step_end = (step == ssc_pkg::STEP_W'(ssc_pkg::SET_CAPACITY - 1));
  assign slot_free = !m_tvalid || m_tready;

  // Threshold: max(min_change, larger count / 3)
  assign larger = (prev_count > cur_count) ? prev_count : cur_count;
  assign prod   = (ssc_pkg::CNT_W+6)'(larger) * (ssc_pkg::CNT_W+6)'(ssc_pkg::DIV3_MUL);
  assign third  = ssc_pkg::MINC_W'(prod >> ssc_pkg::DIV3_SHIFT);
  assign thresh = (third < min_change) ? min_change : third;
  assign sum    = (ssc_pkg::CNT_W+1)'(gone) + (ssc_pkg::CNT_W+1)'(fresh);
  assign changed = compared &&
                   (ssc_pkg::CMP_W'(sum) >= ssc_pkg::CMP_W'(thresh));
  assign total_next = (changed && (change_total != ssc_pkg::TOTAL_MAX)) ?
                      change_total + 1'b1 : change_total;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ssc_pkg::ST_IDLE: begin
        if (terminal) begin
          state_next = ((prev_count != '0) && (cur_count_next != '0)) ?
                       ssc_pkg::ST_ROTATE : ssc_pkg::ST_FINISH;
        end
      end
      ssc_pkg::ST_ROTATE: begin
        if (step_end) state_next = ssc_pkg::ST_LOAD;
      end
      ssc_pkg::ST_LOAD: begin
        state_next = ssc_pkg::ST_COUNT;
      end
      ssc_pkg::ST_COUNT: begin
        if (step_end) state_next = ssc_pkg::ST_FINISH;
      end
      ssc_pkg::ST_FINISH: begin
        if (slot_free) state_next = ssc_pkg::ST_IDLE;
      end
      default: state_next = ssc_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_tready     = 1'b0;
    fire         = 1'b0;
    ctl          = '0;
    unique case (state)
      ssc_pkg::ST_IDLE: begin
        s_tready   = 1'b1;
        ctl.append = append;
        ctl.start  = terminal;
      end
      ssc_pkg::ST_ROTATE: ctl.rotate = 1'b1;
      ssc_pkg::ST_LOAD:   ctl.load   = 1'b1;
      ssc_pkg::ST_COUNT:  ctl.shift  = 1'b1;
      ssc_pkg::ST_FINISH: begin
        fire         = slot_free;
        ctl.transfer = slot_free;
      end
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled    <= 1'b1;
      min_change <= ssc_pkg::MIN_CHANGE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ssc_pkg::REG_ENABLED:    enabled    <= cfg_wdata[0];
        ssc_pkg::REG_MIN_CHANGE: min_change <= cfg_wdata;
        default:                 enabled    <= enabled;
      endcase
    end
  end

  // Set counts, step counter and miss tallies
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_count    <= '0;
      prev_count   <= '0;
      step         <= '0;
      gone         <= '0;
      fresh        <= '0;
      compared     <= 1'b0;
      change_total <= '0;
    end else begin
      if (state == ssc_pkg::ST_IDLE) begin
        cur_count <= cur_count_next;
        step      <= '0;
        if (terminal) begin
          compared <= (prev_count != '0) && (cur_count_next != '0);
          gone     <= '0;
          fresh    <= '0;
        end
      end
      if (state == ssc_pkg::ST_ROTATE || state == ssc_pkg::ST_COUNT) begin
        step <= step + 1'b1;
      end
      if (state == ssc_pkg::ST_LOAD) begin
        step <= '0;
      end
      if (state == ssc_pkg::ST_COUNT) begin
        gone  <= gone + ssc_pkg::CNT_W'(tail_gone);
        fresh <= fresh + ssc_pkg::CNT_W'(tail_fresh);
      end
      if (fire) begin
        prev_count   <= cur_count;
        cur_count    <= '0;
        change_total <= total_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= ssc_pkg::OUT_DATA_W'({ssc_pkg::OUT_CNT_W'(fresh),
                                       ssc_pkg::OUT_CNT_W'(gone),
                                       compared, changed, total_next});
    end
  end

endmodule

// ----- hdl/scan_set_change_counter_top.sv -----
// ----------------------------------------------------------------------------
// scan_set_change_counter_top: scene-change counter over access-point scans
// Collects the identifiers of each scan and compares them with the previous
// scan when the scan ends, counting scans whose change reaches a threshold.
// ----------------------------------------------------------------------------
// An identifier beat that does not end a scan is taken at once. A beat that
// ends a scan holds s_tready low while the row of SET_CAPACITY cells does
// the comparison: the current set rotates once around the ring (one
// comparator per cell), the load state captures the miss flags, and the
// flags drain past the tail counter; the finish state then applies the
// threshold and loads the result, waiting for the previous result to be
// taken. When no comparison is needed (either set empty) the rotation and
// drain are skipped. Identifier beats arriving while enabled is 0 are taken
// and discarded.
module scan_set_change_counter_top (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [ssc_pkg::REG_ADDR_W-1:0]      cfg_addr,
  input  logic [ssc_pkg::MINC_W-1:0]          cfg_wdata,
  // Identifier stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ssc_pkg::ID_W-1:0]            s_tdata,   // [47:0] station_id
  input  logic                                s_tlast,   // last
  input  logic                                s_tuser,   // no_entry
  // Result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [30:0] change_total, [31] changed, [32] compared,
  // [38:33] gone_count, [44:39] fresh_count, [47:45] zero
  output logic [ssc_pkg::OUT_DATA_W-1:0]      m_tdata
);

  localparam int N = ssc_pkg::SET_CAPACITY;

  ssc_pkg::cell_ctl_t             ctl;
  logic [ssc_pkg::ID_W-1:0]       id_link    [N];
  logic                           valid_link [N];
  logic                           found_link [N];
  logic                           gone_link  [N];
  logic                           fresh_link [N];
  logic [ssc_pkg::ID_W-1:0]       head_id;
  logic                           head_valid;

  // Feed cell 0: the new identifier on append, the ring tail on rotate
  assign head_id    = ctl.append ? s_tdata : id_link[N-1];
  assign head_valid = ctl.append ? 1'b1    : valid_link[N-1];

  ssc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tlast    (s_tlast),
    .s_tuser    (s_tuser),
    .s_tready   (s_tready),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .m_tdata    (m_tdata),
    .tail_gone  (gone_link[N-1]),
    .tail_fresh (fresh_link[N-1]),
    .ctl        (ctl)
  );

  // Row of cells, closed into a ring for the current set
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_head
      ssc_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .id_in     (head_id),
        .valid_in  (head_valid),
        .found_in  (found_link[N-1]),
        .gone_in   (1'b0),
        .fresh_in  (1'b0),
        .id_out    (id_link[i]),
        .valid_out (valid_link[i]),
        .found_out (found_link[i]),
        .gone_out  (gone_link[i]),
        .fresh_out (fresh_link[i])
      );
    end else begin : g_body
      ssc_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .id_in     (id_link[i-1]),
        .valid_in  (valid_link[i-1]),
        .found_in  (found_link[i-1]),
        .gone_in   (gone_link[i-1]),
        .fresh_in  (fresh_link[i-1]),
        .id_out    (id_link[i]),
        .valid_out (valid_link[i]),
        .found_out (found_link[i]),
        .gone_out  (gone_link[i]),
        .fresh_out (fresh_link[i])
      );
    end
  end

endmodule

// ----- hdl/ssc_checker.sv -----
// ----------------------------------------------------------------------------
// ssc_checker: port-level checks for the scan set change counter
// Watches the result stream of the top level; attached by bind below.
// ----------------------------------------------------------------------------
module ssc_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [ssc_pkg::OUT_DATA_W-1:0]      m_tdata
);

  logic                              r_changed;
  logic                              r_compared;
  logic [ssc_pkg::OUT_CNT_W-1:0]     r_gone;
  logic [ssc_pkg::OUT_CNT_W-1:0]     r_fresh;

  assign r_changed  = m_tdata[ssc_pkg::TOTAL_W];
  assign r_compared = m_tdata[ssc_pkg::TOTAL_W + 1];
  assign r_gone     = m_tdata[ssc_pkg::TOTAL_W + 2 +: ssc_pkg::OUT_CNT_W];
  assign r_fresh    = m_tdata[ssc_pkg::TOTAL_W + 2 + ssc_pkg::OUT_CNT_W +: ssc_pkg::OUT_CNT_W];

  // Hold a stalled result beat
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result beat changed while stalled");

  // A counted change needs a comparison
  a_changed_compared: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!r_changed || r_compared))
    else $error("change flagged without comparison");

  // No comparison leaves both tallies at zero
  a_idle_counts: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !r_compared |-> (r_gone == '0) && (r_fresh == '0))
    else $error("nonzero tallies without comparison");

  // Upper padding stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[ssc_pkg::OUT_DATA_W-1:ssc_pkg::OUT_USED_W] == '0))
    else $error("result padding not zero");

endmodule

bind scan_set_change_counter_top ssc_checker u_ssc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the scan set change counter
// Drives scans of access-point identifiers into the block, predicts the
// per-scan summary (gone and fresh counts, threshold and change total) and
// checks every summary beat against the prediction. Both sides idle and
// stall at random across several phases and min_change settings.
// ----------------------------------------------------------------------------
module tb_top;
  import ssc_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 4;
  localparam int SETTLE_CYCLES = 80;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int PHASE_ITEMS   = 225;
  localparam int NUM_PHASES    = 8;
  localparam int LONG_STALL    = 400;
  localparam int MAX_REPORTS   = 10;
  localparam int THRESH_DIV    = 3;

  // Summary fields, last field in the lowest bits
  typedef struct packed {
    logic [OUT_CNT_W-1:0] fresh;
    logic [OUT_CNT_W-1:0] gone;
    logic                 compared;
    logic                 changed;
    logic [TOTAL_W-1:0]   total;
  } scan_summary_t;

  // Tracks the previous and current identifier sets and the change total,
  // and holds the summaries still owed by the block.
  class scan_scoreboard;
    logic [ID_W-1:0]    prev_ids[$];
    logic [ID_W-1:0]    cur_ids[$];
    logic [TOTAL_W-1:0] total;
    bit                 enabled;
    logic [MINC_W-1:0]  min_change;
    scan_summary_t      owed[$];
    int                 errors;

    function new();
      total      = '0;
      enabled    = 1'b1;
      min_change = MIN_CHANGE_RST;
      errors     = 0;
    endfunction

    function void write_reg(logic [REG_ADDR_W-1:0] addr, logic [MINC_W-1:0] value);
      case (addr)
        REG_ENABLED:    enabled = value[0];
        REG_MIN_CHANGE: min_change = value;
        default: ;
      endcase
    endfunction

    function bit holds(logic [ID_W-1:0] ids[$], logic [ID_W-1:0] id);
      foreach (ids[i]) begin
        if (ids[i] == id) return 1'b1;
      end
      return 1'b0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Apply one accepted input beat; a scan end owes one summary
    function void note_beat(logic [ID_W-1:0] id, bit is_last, bit no_entry);
      scan_summary_t s;
      int gone;
      int fresh;
      int larger;
      int thresh;
      if (!enabled) return;
      if (!no_entry && cur_ids.size() < SET_CAPACITY) cur_ids.push_back(id);
      if (!is_last && !no_entry) return;
      s = '0;
      if (prev_ids.size() > 0 && cur_ids.size() > 0) begin
        gone  = 0;
        fresh = 0;
        foreach (prev_ids[i]) begin
          if (!holds(cur_ids, prev_ids[i])) gone++;
        end
        foreach (cur_ids[i]) begin
          if (!holds(prev_ids, cur_ids[i])) fresh++;
        end
        larger = (prev_ids.size() > cur_ids.size()) ? prev_ids.size() : cur_ids.size();
        thresh = larger / THRESH_DIV;
        if (thresh < min_change) thresh = min_change;
        s.compared = 1'b1;
        s.gone     = OUT_CNT_W'(gone);
        s.fresh    = OUT_CNT_W'(fresh);
        if (gone + fresh >= thresh) begin
          s.changed = 1'b1;
          if (total != TOTAL_MAX) total++;
        end
      end
      s.total = total;
      owed.push_back(s);
      prev_ids = cur_ids;
      cur_ids.delete();
    endfunction

    // Compare one summary beat with the oldest owed summary
    function void check_result(logic [OUT_DATA_W-1:0] data);
      scan_summary_t got;
      scan_summary_t want;
      logic [OUT_DATA_W-OUT_USED_W-1:0] pad;
      got = data[OUT_USED_W-1:0];
      pad = data[OUT_DATA_W-1:OUT_USED_W];
      if (owed.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected summary beat: %h", data);
        return;
      end
      want = owed.pop_front();
      if (got.total !== want.total || got.changed !== want.changed ||
          got.compared !== want.compared || got.gone !== want.gone ||
          got.fresh !== want.fresh || pad !== '0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display({"summary mismatch: exp total=%0d changed=%0b compared=%0b gone=%0d ",
                    "fresh=%0d | got total=%0d changed=%0b compared=%0b gone=%0d fresh=%0d ",
                    "pad=%h"},
                   want.total, want.changed, want.compared, want.gone, want.fresh,
                   got.total, got.changed, got.compared, got.gone, got.fresh, pad);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [REG_ADDR_W-1:0] cfg_addr = REG_ENABLED;
  logic [MINC_W-1:0]     cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [ID_W-1:0]       s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  scan_scoreboard  sb;
  int              tx_idle_pct = 0;
  int              rx_stall_pct = 0;
  int              stall_req = 0;
  int              stall_seen = 0;
  int              stall_left = 0;
  int              cycle_count = 0;
  int              items_sent = 0;
  logic [ID_W-1:0] recent_ids[$];
  logic [MINC_W-1:0] minc_list[NUM_PHASES] = '{7'd3, 7'd1, 7'd64, 7'd0, 7'd2, 7'd5, 7'd10, 7'd64};
  int              tx_list[4] = '{0, 82, 0, 27};
  int              rx_list[4] = '{0, 0, 82, 27};

  scan_set_change_counter_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    clk = 1'b1;
    #CLK_HALF;
    clk = 1'b0;
    #CLK_HALF;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (stall_req != stall_seen) begin
      stall_seen <= stall_req;
      stall_left <= LONG_STALL;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Check every summary beat
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // Offer one beat and hold it until taken; valid stays high for a follow-on
  task automatic send_beat(logic [ID_W-1:0] id, bit is_last, bit no_entry);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= id;
    s_tlast  <= is_last;
    s_tuser  <= no_entry;
    do @(posedge clk); while (!s_tready);
    if (sb.enabled) items_sent++;
    sb.note_beat(id, is_last, no_entry);
  endtask

  // Drop valid, wait for every owed summary, then let the block go idle
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(bit en, logic [MINC_W-1:0] minc);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_ENABLED;
    cfg_wdata <= MINC_W'(en);
    @(posedge clk);
    sb.write_reg(REG_ENABLED, MINC_W'(en));
    cfg_addr  <= REG_MIN_CHANGE;
    cfg_wdata <= minc;
    @(posedge clk);
    sb.write_reg(REG_MIN_CHANGE, minc);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mix wide random ids with narrow pools near zero and all-ones
  function automatic logic [ID_W-1:0] pick_new_id();
    case ($urandom_range(3))
      0:       return ID_W'($urandom_range(15));
      1:       return {{(ID_W-4){1'b1}}, 4'($urandom_range(15))};
      default: return ID_W'({$urandom(), $urandom()});
    endcase
  endfunction

  // Mostly short scans, some empty, some past capacity
  function automatic int pick_scan_len();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 0;
    if (r < 65) return $urandom_range(1, 8);
    if (r < 90) return $urandom_range(9, SET_CAPACITY - 1);
    return $urandom_range(SET_CAPACITY, SET_CAPACITY + 8);
  endfunction

  // One scan: ids reused from the last scan, repeated, or new
  task automatic send_scan(int n, int reuse_pct, bit end_by_no_entry);
    logic [ID_W-1:0] ids[$];
    logic [ID_W-1:0] id;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < reuse_pct && recent_ids.size() > 0)
        id = recent_ids[$urandom_range(recent_ids.size() - 1)];
      else if (r < reuse_pct + 5 && ids.size() > 0)
        id = ids[$urandom_range(ids.size() - 1)];
      else
        id = pick_new_id();
      ids.push_back(id);
      send_beat(id, !end_by_no_entry && (i == n - 1), 1'b0);
    end
    if (end_by_no_entry || n == 0) send_beat(pick_new_id(), 1'($urandom_range(1)), 1'b1);
    if (ids.size() > 0) recent_ids = ids;
  endtask

  initial begin
    int  target;
    bit  midway;
    sb = new();
    minc_list[4] = MINC_W'($urandom_range(1, 64));
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_regs(1'b1, MIN_CHANGE_RST);

    // Empty scan with nothing stored yet, then a single all-zero id
    send_beat(48'h0000_0000_0000, 1'b0, 1'b1);
    send_beat(48'h0000_0000_0000, 1'b1, 1'b0);
    send_beat(48'hFFFF_FFFF_FFFF, 1'b0, 1'b0);
    send_beat(48'h0000_0000_0000, 1'b1, 1'b0);
    // Repeated id; the no-entry beat ends the scan and its id is not kept
    send_beat(48'hA5A5_A5A5_A5A5, 1'b0, 1'b0);
    send_beat(48'hA5A5_A5A5_A5A5, 1'b0, 1'b0);
    send_beat(48'h1234_5678_9ABC, 1'b1, 1'b1);
    settle();

    // Zero floor: even an unchanged scan counts
    set_regs(1'b1, 7'd0);
    send_beat(48'hA5A5_A5A5_A5A5, 1'b0, 1'b0);
    send_beat(48'hA5A5_A5A5_A5A5, 1'b1, 1'b0);
    settle();
    set_regs(1'b1, 7'd64);
    send_beat(48'hFFFF_FFFF_FFFF, 1'b0, 1'b0);
    send_beat(48'h5A5A_5A5A_5A5A, 1'b1, 1'b0);
    settle();

    // Disabled: beats are taken and dropped
    set_regs(1'b0, 7'd64);
    send_beat(48'hFFFF_FFFF_FFFF, 1'b1, 1'b0);
    send_beat(48'h0000_0000_0000, 1'b0, 1'b1);
    send_beat(48'h0000_0000_0003, 1'b0, 1'b0);
    settle();
    set_regs(1'b1, 7'd1);
    send_beat(48'h0000_0000_0003, 1'b1, 1'b0);
    send_beat(48'h0000_0000_0000, 1'b1, 1'b1);

    // Random scans across idling modes and thresholds
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      set_regs(1'b1, minc_list[ph]);
      tx_idle_pct = tx_list[ph % 4];
      rx_stall_pct <= rx_list[ph % 4];
      target = items_sent + PHASE_ITEMS;
      midway = 1'b0;
      while (items_sent < target) begin
        if (!midway && items_sent >= target - PHASE_ITEMS / 2) begin
          midway = 1'b1;
          if (ph == 0 || ph == 2) stall_req <= stall_req + 1;
          if (ph == 1) settle();
        end
        send_scan(pick_scan_len(), $urandom_range(100), ($urandom_range(3) == 0));
      end
      if (ph == 3) begin
        settle();
        set_regs(1'b0, minc_list[ph]);
        repeat (10) send_beat(pick_new_id(), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end

    settle();
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
